@@ rtl/pixrle_pkg.sv @@
// Shared types and constants for the PIX run-length image decoder.
// No dependencies; every other file in rtl/ imports this package.
package pixrle_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RUNS   = 2'd1,
        PH_HALT   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_RUN    = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    // Header byte positions that carry data; all others are skipped.
    localparam logic [3:0] HDR_WIDTH_HI  = 4'd0;
    localparam logic [3:0] HDR_WIDTH_LO  = 4'd1;
    localparam logic [3:0] HDR_HEIGHT_HI = 4'd2;
    localparam logic [3:0] HDR_HEIGHT_LO = 4'd3;
    localparam logic [3:0] HDR_DEPTH_HI  = 4'd8;
    localparam logic [3:0] HDR_DEPTH_LO  = 4'd9;

    // Byte positions within one run.
    localparam logic [3:0] RUN_COUNT = 4'd0;
    localparam logic [3:0] RUN_BLUE  = 4'd1;
    localparam logic [3:0] RUN_GREEN = 4'd2;

    localparam logic [15:0] GOOD_DEPTH = 16'd24;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  run_length;
        logic [15:0] start_column;
        logic [15:0] row_index;
        logic        line_end;
        logic        image_end;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } result_t;

endpackage

@@ rtl/pixrle_parser.sv @@
// Byte parser: header fields, run assembly, column and row tracking.
// Depends on pixrle_pkg.
module pixrle_parser
    import pixrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    output logic       res_valid,
    output result_t    res,
    output logic       halted
);

    phase_t      phase_reg,    phase_next;
    logic [3:0]  position_reg, position_next;
    logic [15:0] width_reg,    width_next;
    logic [15:0] height_reg,   height_next;
    logic [7:0]  depth_hi_reg, depth_hi_next;
    logic [15:0] row_reg,      row_next;
    logic [16:0] column_reg,   column_next;
    logic [7:0]  count_reg,    count_next;
    logic [7:0]  blue_reg,     blue_next;
    logic [7:0]  green_reg,    green_next;

    logic [15:0] depth;
    logic [15:0] start;
    logic [15:0] room;
    logic [7:0]  len;
    logic [16:0] col_sum;
    logic        line_done;
    logic [15:0] row_inc;

    // Run geometry: clip the run to the room left in the line.
    always_comb
    begin
        depth     = {depth_hi_reg, data_byte};
        start     = (column_reg < {1'b0, width_reg}) ? column_reg[15:0] : width_reg;
        room      = width_reg - start;
        len       = ({8'd0, count_reg} < room) ? count_reg : room[7:0];
        col_sum   = column_reg + {9'd0, count_reg};
        line_done = (col_sum >= {1'b0, width_reg});
        row_inc   = row_reg + 16'd1;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        position_next = position_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        depth_hi_next = depth_hi_reg;
        row_next      = row_reg;
        column_next   = column_reg;
        count_next    = count_reg;
        blue_next     = blue_reg;
        green_next    = green_reg;
        res_valid     = 1'b0;
        res              = '0;
        res.image_width  = width_reg;
        res.image_height = height_reg;

        unique case (phase_reg)
            PH_HEADER:
            begin
                position_next = position_reg + 4'd1;
                priority case (position_reg)
                    HDR_WIDTH_HI:  width_next[15:8]  = data_byte;
                    HDR_WIDTH_LO:  width_next[7:0]   = data_byte;
                    HDR_HEIGHT_HI: height_next[15:8] = data_byte;
                    HDR_HEIGHT_LO: height_next[7:0]  = data_byte;
                    HDR_DEPTH_HI:  depth_hi_next     = data_byte;
                    HDR_DEPTH_LO:
                    begin
                        position_next = '0;
                        res_valid     = 1'b1;
                        if (depth != GOOD_DEPTH)
                        begin
                            phase_next = PH_HALT;
                            res.kind   = KIND_ERROR;
                        end
                        else
                        begin
                            row_next    = '0;
                            column_next = '0;
                            res.kind    = KIND_HEADER;
                            if (height_reg == 16'd0)
                            begin
                                res.image_end = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_RUNS;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            PH_RUNS:
            begin
                priority if (position_reg == RUN_COUNT)
                begin
                    count_next    = data_byte;
                    position_next = RUN_BLUE;
                end
                else if (position_reg == RUN_BLUE)
                begin
                    blue_next     = data_byte;
                    position_next = RUN_GREEN;
                end
                else if (position_reg == RUN_GREEN)
                begin
                    green_next    = data_byte;
                    position_next = position_reg + 4'd1;
                end
                else
                begin
                    // Red byte closes the run.
                    position_next    = '0;
                    column_next      = col_sum;
                    res_valid        = 1'b1;
                    res.kind         = KIND_RUN;
                    res.red          = data_byte;
                    res.green        = green_reg;
                    res.blue         = blue_reg;
                    res.run_length   = len;
                    res.start_column = start;
                    res.row_index    = row_reg;
                    if (line_done)
                    begin
                        res.line_end = 1'b1;
                        column_next  = '0;
                        row_next     = row_inc;
                        if (row_inc == height_reg)
                        begin
                            res.image_end = 1'b1;
                            phase_next    = PH_HEADER;
                            row_next      = '0;
                        end
                    end
                end
            end
            PH_HALT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            position_reg <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            depth_hi_reg <= '0;
            row_reg      <= '0;
            column_reg   <= '0;
            count_reg    <= '0;
            blue_reg     <= '0;
            green_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            depth_hi_reg <= depth_hi_next;
            row_reg      <= row_next;
            column_reg   <= column_next;
            count_reg    <= count_next;
            blue_reg     <= blue_next;
            green_reg    <= green_next;
        end
    end

    assign halted = (phase_reg == PH_HALT);

endmodule

@@ rtl/pixrle_outbuf.sv @@
// Output register with a skid stage for result words.
// Depends on pixrle_pkg.
module pixrle_outbuf
    import pixrle_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg,   out_data_next;
    result_t skid_data_reg,  skid_data_next;
    logic    out_taken;

    always_comb
    begin
        out_taken       = out_valid_reg && !out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        priority if (skid_valid_reg)
        begin
            // Input is stalled here; drain the skid word into the output.
            if (out_taken)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_taken)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_taken)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/pix_rle_image_decoder.sv @@
// PIX 24-bit run-length decoder, top level; one file byte per input word.
// A result word is registered, into the skid stage if the output register is occupied.
// Throughput: one byte per cycle, halted by in_stall only while the skid stage is full.
// Reset (rst_n low, async): header parsing from byte 0, all counters zero, buffers empty.
// Depends on pixrle_pkg, pixrle_parser, pixrle_outbuf.
module pix_rle_image_decoder
    import pixrle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  out_kind,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  run_length,
    output logic [15:0] start_column,
    output logic [15:0] row_index,
    output logic        line_end,
    output logic        image_end,
    output logic [15:0] image_width,
    output logic [15:0] image_height
);

    logic    in_accept;
    logic    res_valid;
    result_t res;
    logic    halted;
    logic    buf_full;
    result_t out_word;

    // Accept a byte whenever the skid stage is free; the output register
    // may still hold an untaken word at that point.
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !in_stall;

    // Parse the byte and update header/run state in the same cycle.
    pixrle_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (data_byte),
        .res_valid (res_valid),
        .res       (res),
        .halted    (halted)
    );

    // Register the result word; overflow into the skid stage under stall.
    pixrle_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept && res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_word)
    );

    // Fan the result word out to its field ports.
    assign out_kind     = out_word.kind;
    assign red          = out_word.red;
    assign green        = out_word.green;
    assign blue         = out_word.blue;
    assign run_length   = out_word.run_length;
    assign start_column = out_word.start_column;
    assign row_index    = out_word.row_index;
    assign line_end     = out_word.line_end;
    assign image_end    = out_word.image_end;
    assign image_width  = out_word.image_width;
    assign image_height = out_word.image_height;

    // After a bad depth, no byte may produce a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        halted |-> !res_valid)
        else $error("result produced while halted");

    // A full skid stage means the output register is occupied too.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("skid stage full with empty output register");

    // A run that does not end its line must fit strictly inside the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_RUN && !res.line_end) |->
        (({1'b0, res.start_column} + {9'd0, res.run_length}) < {1'b0, res.image_width}))
        else $error("open run reaches past line width");

    // An error word never closes an image.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_ERROR) |-> !res.image_end)
        else $error("error word flagged as image end");

endmodule
